FILE: src/srtoc_pkg.sv
// Shared types and constants of the sorted region table.
`default_nettype none

package srtoc_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int USED_W      = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] span;
    logic [7:0]  ident;
  } entry_t;

endpackage

`default_nettype wire

FILE: src/sorted_region_table_overlap_check.sv
// Insert: scan to the insert point, check its neighbours for overlap, shift later entries
//   up, then place the region. Remove: find the first entry with the id, shift later entries
//   down. Full tables and empty removes skip to the result; empty inserts skip the scan.
// Throughput: one item at a time; the next is taken in the cycle after its result issues,
//   later while an earlier result still waits. Scans and shifts move one entry per cycle.
// Reset: synchronous, active high; clears the count and the output valid, not the memory.
`default_nettype none

module sorted_region_table_overlap_check import srtoc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,   // region_id[7:0], base[71:8], span[135:72]
  input  wire logic [0:0]   s_axis_tuser,   // op[0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata    // status[1:0], entries_used[6:2], zero[7]
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHDN  = 6'b000100,
    S_SHUP  = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] widx;
  logic             op_r;
  logic [7:0]       id_r;
  logic [63:0]      base_r;
  logic [63:0]      span_r;
  logic [63:0]      end_new;
  logic [63:0]      prev_end;
  status_t          status_r;
  logic [1:0]       out_status;
  logic [USED_W-1:0] out_used;

  // Entry memory with registered read
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // Scan decisions on the entry just read
  logic [63:0]      cur_end;
  logic             at_last;
  logic             ins_stop;
  logic             ins_ovl_here;
  logic             ins_ovl_tail;
  logic             rm_hit;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {1'b0, out_used, out_status};

  assign cur_end      = rd_data.base + rd_data.span;
  assign at_last      = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign ins_stop     = !(base_r > rd_data.base);
  assign ins_ovl_here = (end_new > rd_data.base) || ((idx != '0) && (prev_end > base_r));
  assign ins_ovl_tail = (cur_end > base_r);
  assign rm_hit       = (rd_data.ident == id_r);

  // Pick read address and write port for this cycle
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = widx;
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
      end
      S_SCAN: begin
        if (op_r == OP_INSERT && ins_stop) begin
          rd_addr = IDX_W'(count - CNT_W'(1));
        end else begin
          rd_addr = idx + IDX_W'(1);
        end
      end
      S_SHDN: begin
        rd_addr = widx - IDX_W'(2);
        wr_en   = 1'b1;
      end
      S_SHUP: begin
        rd_addr = widx + IDX_W'(2);
        wr_en   = 1'b1;
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = '{base: base_r, span: span_r, ident: id_r};
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop a delivered result unless a new one replaces it below
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_r    <= s_axis_tuser[0];
            id_r    <= s_axis_tdata[7:0];
            base_r  <= s_axis_tdata[71:8];
            span_r  <= s_axis_tdata[135:72];
            end_new <= s_axis_tdata[71:8] + s_axis_tdata[135:72];
            idx     <= '0;
            if (s_axis_tuser[0] == OP_INSERT) begin
              if (count == CNT_W'(TABLE_DEPTH)) begin
                status_r <= ST_FULL;
                state    <= S_DONE;
              end else if (count == '0) begin
                pos   <= '0;
                state <= S_PLACE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (count == '0) begin
                status_r <= ST_NOTFOUND;
                state    <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (op_r == OP_INSERT) begin
            if (ins_stop) begin
              if (ins_ovl_here) begin
                status_r <= ST_OVERLAP;
                state    <= S_DONE;
              end else begin
                pos   <= idx;
                widx  <= IDX_W'(count);
                state <= S_SHDN;
              end
            end else begin
              prev_end <= cur_end;
              if (at_last) begin
                if (ins_ovl_tail) begin
                  status_r <= ST_OVERLAP;
                  state    <= S_DONE;
                end else begin
                  pos   <= IDX_W'(count);
                  state <= S_PLACE;
                end
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end
          end else begin
            if (rm_hit) begin
              if (at_last) begin
                count    <= count - CNT_W'(1);
                status_r <= ST_OK;
                state    <= S_DONE;
              end else begin
                widx  <= idx;
                state <= S_SHUP;
              end
            end else if (at_last) begin
              status_r <= ST_NOTFOUND;
              state    <= S_DONE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_SHDN: begin
          // Move entries up by one, from the end down to the insert position
          if ((widx - IDX_W'(1)) == pos) begin
            state <= S_PLACE;
          end else begin
            widx <= widx - IDX_W'(1);
          end
        end
        S_SHUP: begin
          // Close the gap left by the removed entry
          if ((CNT_W'(widx) + CNT_W'(2)) == count) begin
            count    <= count - CNT_W'(1);
            status_r <= ST_OK;
            state    <= S_DONE;
          end else begin
            widx <= widx + IDX_W'(1);
          end
        end
        S_PLACE: begin
          count    <= count + CNT_W'(1);
          status_r <= ST_OK;
          state    <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= status_r;
            out_used      <= USED_W'(count);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/srtoc_checker.sv
// Port-level checks of the sorted region table and their binding.
`default_nettype none

module srtoc_checker import srtoc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic [1:0]        st;
  logic [USED_W-1:0] used;
  logic [USED_W-1:0] last_used;
  logic              seen;
  logic              rejected;

  assign st       = m_axis_tdata[1:0];
  assign used     = m_axis_tdata[6:2];
  assign rejected = (st == ST_OVERLAP) || (st == ST_NOTFOUND);

  // Track the count reported by the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_used <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen      <= 1'b1;
      last_used <= used;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (st == ST_FULL) |-> used == USED_W'(TABLE_DEPTH))
    else $error("table full reported below depth");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && rejected |-> used == (seen ? last_used : '0))
    else $error("rejected item changed the entry count");

endmodule

bind sorted_region_table_overlap_check srtoc_checker u_srtoc_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking bench for the sorted region table: driver, result checker and table predictor.
`timescale 1ns / 100ps

module testbench;
  import srtoc_pkg::*;

  // One table operation as presented on the input stream
  typedef struct {
    logic        op;
    logic [7:0]  region_id;
    logic [63:0] base;
    logic [63:0] span;
  } region_op_t;

  // One result as the table should report it
  typedef struct {
    status_t     status;
    logic [4:0]  entries_used;
  } table_reply_t;

  typedef enum int {NO_IDLE, SEND_IDLE, RECV_IDLE, BOTH_IDLE} idle_mode_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;   // region_id[7:0], base[71:8], span[135:72]
  logic [0:0]   s_axis_tuser = '0;   // op[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;        // status[1:0], entries_used[6:2], zero[7]

  region_op_t   ops_waiting[$];
  table_reply_t replies_due[$];
  idle_mode_t   idle_mode = NO_IDLE;
  int           fail_count = 0;
  int           n_placed = 0, n_overlap = 0, n_full = 0, n_removed = 0, n_missing = 0;

  // Predicted table contents, sorted by base
  logic [63:0]  held_base[TABLE_DEPTH];
  logic [63:0]  held_span[TABLE_DEPTH];
  logic [7:0]   held_ident[TABLE_DEPTH];
  int unsigned  held_count = 0;

  sorted_region_table_overlap_check dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one operation to the predicted table and return its status
  function automatic status_t apply_region_op(logic op, logic [7:0] id,
                                               logic [63:0] base, logic [63:0] span);
    int unsigned pos;
    int unsigned k;
    logic [63:0] new_end;
    logic [63:0] prev_end;
    if (op == OP_INSERT) begin
      if (held_count >= TABLE_DEPTH) return ST_FULL;
      pos = 0;
      if (held_count > 0) begin
        // find the first entry whose base is not below the new base
        while (pos < held_count) begin
          if (!(base > held_base[pos])) break;
          pos++;
        end
        new_end = base + span;
        if (pos < held_count && new_end > held_base[pos]) return ST_OVERLAP;
        if (pos > 0) begin
          prev_end = held_base[pos - 1] + held_span[pos - 1];
          if (prev_end > base) return ST_OVERLAP;
        end
      end
      // open a slot at pos and place the region
      for (k = held_count; k > pos; k--) begin
        held_base[k]  = held_base[k - 1];
        held_span[k]  = held_span[k - 1];
        held_ident[k] = held_ident[k - 1];
      end
      held_base[pos]  = base;
      held_span[pos]  = span;
      held_ident[pos] = id;
      held_count++;
      return ST_OK;
    end
    // remove the first entry in table order with this id
    for (pos = 0; pos < held_count; pos++) begin
      if (held_ident[pos] == id) begin
        for (k = pos; k + 1 < held_count; k++) begin
          held_base[k]  = held_base[k + 1];
          held_span[k]  = held_span[k + 1];
          held_ident[k] = held_ident[k + 1];
        end
        held_count--;
        return ST_OK;
      end
    end
    return ST_NOTFOUND;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Build a random operation: mostly regions packed near a cluster so that
  // overlaps, exact abutment and full tables are common; ids from a small pool
  function automatic region_op_t random_region_op(int insert_pct, logic [63:0] cluster);
    region_op_t r;
    int pick;
    r.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    r.region_id = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, 31))
                                               : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (r.op == OP_REMOVE) begin
      r.base = rand64();
      r.span = rand64();
    end else if (pick < 70) begin
      r.base = cluster + 64'($urandom_range(0, 2047));
      r.span = 64'($urandom_range(0, 160));
    end else if (pick < 85) begin
      r.base = rand64();
      r.span = 64'($urandom_range(0, 4095));
    end else begin
      r.base = rand64();
      r.span = rand64();
    end
    return r;
  endfunction

  function automatic region_op_t region_op(logic op, logic [7:0] id,
                                           logic [63:0] base, logic [63:0] span);
    region_op_t r;
    r.op = op;
    r.region_id = id;
    r.base = base;
    r.span = span;
    return r;
  endfunction

  // Drive items from the waiting queue; predict each one as it is accepted
  always @(posedge clk) begin : drive_items
    bit           fire;
    bit           go;
    table_reply_t reply;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        reply.status = apply_region_op(s_axis_tuser[0], s_axis_tdata[7:0],
                                       s_axis_tdata[71:8], s_axis_tdata[135:72]);
        reply.entries_used = 5'(held_count);
        replies_due.push_back(reply);
        case (reply.status)
          ST_OK:       if (s_axis_tuser[0] == OP_INSERT) n_placed++; else n_removed++;
          ST_OVERLAP:  n_overlap++;
          ST_NOTFOUND: n_missing++;
          default:     n_full++;
        endcase
        void'(ops_waiting.pop_front());
      end
      // hold a presented item until it is taken
      if (!s_axis_tvalid || fire) begin
        go = ops_waiting.size() > 0;
        if (idle_mode == SEND_IDLE && $urandom_range(0, 99) < 76) go = 1'b0;
        if (idle_mode == BOTH_IDLE && $urandom_range(0, 99) < 31) go = 1'b0;
        s_axis_tvalid <= go;
        if (go) begin
          s_axis_tdata <= {ops_waiting[0].span, ops_waiting[0].base, ops_waiting[0].region_id};
          s_axis_tuser <= ops_waiting[0].op;
        end
      end
    end
  end

  // Check each result against the oldest prediction; stall at random in the receive idle modes
  always @(posedge clk) begin : check_results
    table_reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata[1:0] != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[6:2] != want.entries_used) begin
            $display("%0t: entries_used expected %0d actual %0d", $time,
                     want.entries_used, m_axis_tdata[6:2]);
            fail_count++;
          end
          if (m_axis_tdata[7] !== 1'b0) begin
            $display("%0t: pad bit expected 0 actual %b", $time, m_axis_tdata[7]);
            fail_count++;
          end
        end
      end
      if (idle_mode == RECV_IDLE)      m_axis_tready <= ($urandom_range(0, 99) >= 76);
      else if (idle_mode == BOTH_IDLE) m_axis_tready <= ($urandom_range(0, 99) >= 31);
      else                             m_axis_tready <= 1'b1;
    end
  end

  // Stimulus: directed corner cases, then random phases
  initial begin : stimulus
    int phase;
    int i;
    int insert_pct;
    logic [63:0] cluster;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, abutment, overlap on either side, zero span, wrapping sums
    ops_waiting.push_back(region_op(OP_REMOVE, 8'h05, '0, '0));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h00, 64'h1000, 64'h100));
    ops_waiting.push_back(region_op(OP_INSERT, 8'hFF, 64'h1100, 64'h100));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h10, 64'h10F0, 64'h20));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h11, 64'h0F80, 64'h81));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h01, 64'h0F80, 64'h80));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h02, 64'h1000, 64'h0));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h80, 64'h0, 64'h0));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h7F, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20));
    ops_waiting.push_back(region_op(OP_INSERT, 8'hAA, 64'hFFFF_FFFF_FFFF_FF00,
                                    64'hFFFF_FFFF_FFFF_FFFF));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h55, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1));
    // duplicate ids: removes take the first match, then report not found
    ops_waiting.push_back(region_op(OP_INSERT, 8'h02, 64'h2000, 64'h10));
    ops_waiting.push_back(region_op(OP_REMOVE, 8'h02, '0, '0));
    ops_waiting.push_back(region_op(OP_REMOVE, 8'h02, '1, '1));
    ops_waiting.push_back(region_op(OP_REMOVE, 8'h02, '0, '0));
    ops_waiting.push_back(region_op(OP_REMOVE, 8'hFF, 64'h5555_5555_5555_5555,
                                    64'hAAAA_AAAA_AAAA_AAAA));
    // fill the table, then an overlapping insert must still report full
    for (i = 0; i < 10; i++)
      ops_waiting.push_back(region_op(OP_INSERT, 8'(8'h20 + i), 64'h10000 + 64'(i) * 64'h100,
                                      64'h100));
    ops_waiting.push_back(region_op(OP_INSERT, 8'h33, 64'h1000, 64'h10));
    ops_waiting.push_back(region_op(OP_REMOVE, 8'h29, '0, '0));

    // let every prediction drain before the random part
    while (ops_waiting.size() != 0 || replies_due.size() != 0) @(negedge clk);

    for (phase = 0; phase < 14; phase++) begin
      @(negedge clk);
      idle_mode  = idle_mode_t'(phase % 4);
      insert_pct = (phase % 3 == 0) ? 75 : (phase % 3 == 1) ? 55 : 35;
      case (phase % 3)
        0:       cluster = 64'h0;
        1:       cluster = rand64() & ~64'hFFF;
        default: cluster = 64'hFFFF_FFFF_FFFF_F800;
      endcase
      // midway, hold the sender until the table is quiet
      if (phase == 7)
        while (replies_due.size() != 0) @(negedge clk);
      for (i = 0; i < 100; i++)
        ops_waiting.push_back(random_region_op(insert_pct, cluster));
      while (ops_waiting.size() != 0) @(negedge clk);
    end

    while (ops_waiting.size() != 0 || replies_due.size() != 0) @(negedge clk);
    idle_mode = NO_IDLE;
    repeat (64) @(posedge clk);

    $display("Covered %0d placed, %0d overlap rejects, %0d full rejects,",
             n_placed, n_overlap, n_full);
    $display("  %0d removes and %0d missing ids across four idle patterns", n_removed,
             n_missing);
    if (fail_count == 0) begin
      $display("sorted_region_table_overlap_check: match");
    end else begin
      $display("sorted_region_table_overlap_check: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #6_000_000;
    $display("sorted_region_table_overlap_check: mismatch");
    $finish;
  end

endmodule
